// File: hw/rtl/tmse_pkg.sv
`default_nettype none

package tmse_pkg;

    localparam int CMD_W     = 3;
    localparam int STS_W     = 3;
    localparam int STATE_W   = 6;
    localparam int CELL_W    = 10;
    localparam int SYMF_W    = 8;
    localparam int STEP_W    = 32;
    localparam int IN_W      = 48;
    localparam int OUT_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STEP  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [STS_W-1:0] STS_DONE    = 3'd0;
    localparam logic [STS_W-1:0] STS_FINAL   = 3'd1;
    localparam logic [STS_W-1:0] STS_MISSING = 3'd2;
    localparam logic [STS_W-1:0] STS_LIMIT   = 3'd3;
    localparam logic [STS_W-1:0] STS_EDGE    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FINAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 2'd2;

    localparam logic [1:0] MOVE_RIGHT = 2'b01;
    localparam logic [1:0] MOVE_LEFT  = 2'b11;

    typedef struct packed {
        logic clr;
        logic latch;
        logic tbl_write;
        logic cell_write;
        logic run_start;
        logic step_check;
        logic step_commit;
        logic rd_cell;
        logic cdata_latch;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic             clr_last;
        logic [CMD_W-1:0] cmd;
        logic             pre_refuse;
    } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/tmse_ctrl.sv
`default_nettype none

module tmse_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output tmse_pkg::ctl_t     ctl,
    input  wire tmse_pkg::sts_t sts
);
    import tmse_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SYM   = 3'd3;
    localparam logic [2:0] S_TBL   = 3'd4;
    localparam logic [2:0] S_CREAD = 3'd5;
    localparam logic [2:0] S_HREAD = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        ctl           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_CLEAR: begin
                ctl.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    ctl.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_HREAD;
                case (sts.cmd)
                    CMD_LOAD:  ctl.tbl_write = 1'b1;
                    CMD_WRITE: ctl.cell_write = 1'b1;
                    CMD_START: ctl.run_start = 1'b1;
                    CMD_STEP: begin
                        ctl.step_check = 1'b1;
                        if (!sts.pre_refuse) begin
                            state_next = S_SYM;
                        end
                    end
                    CMD_READ: begin
                        ctl.rd_cell = 1'b1;
                        state_next  = S_CREAD;
                    end
                    default: state_next = S_HREAD;
                endcase
            end
            S_SYM: state_next = S_TBL;
            S_TBL: begin
                ctl.step_commit = 1'b1;
                state_next      = S_HREAD;
            end
            S_CREAD: begin
                ctl.cdata_latch = 1'b1;
                state_next      = S_OUT;
            end
            S_HREAD: state_next = S_OUT;
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    ctl.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tmse_dp.sv
`default_nettype none

module tmse_dp #(
    parameter int STATE_COUNT = 64,
    parameter int TAPE_CELLS  = 1024,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tmse_pkg::ctl_t                 ctl,
    output tmse_pkg::sts_t                      sts,
    input  wire logic [tmse_pkg::IN_W-1:0]      s_tdata,
    input  wire logic [tmse_pkg::CMD_W-1:0]     s_tuser,
    input  wire logic                           cfg_we,
    input  wire logic [tmse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tmse_pkg::CFG_W-1:0]     cfg_data,
    output logic [tmse_pkg::OUT_W-1:0]          m_tdata,
    output logic [tmse_pkg::STS_W-1:0]          m_tuser
);
    import tmse_pkg::*;

    localparam int SYM_W       = SYMBOL_BITS;
    localparam int HEAD_W      = $clog2(TAPE_CELLS);
    localparam int ST_W        = $clog2(STATE_COUNT);
    localparam int TI_W        = ST_W + SYM_W;
    localparam int TABLE_DEPTH = STATE_COUNT << SYM_W;
    localparam int CLR_N       = (TAPE_CELLS > TABLE_DEPTH) ? TAPE_CELLS : TABLE_DEPTH;
    localparam int CLR_W       = $clog2(CLR_N);
    localparam int ENT_W       = SYM_W + STATE_W + 3;

    localparam logic [31:0]       STATE_LIM = 32'(STATE_COUNT);
    localparam logic [31:0]       TAPE_LIM  = 32'(TAPE_CELLS);
    localparam logic [31:0]       TBL_LIM   = 32'(TABLE_DEPTH);
    localparam logic [SYM_W-1:0]  BLANK     = SYM_W'(32);
    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(TAPE_CELLS - 1);
    localparam logic [CLR_W-1:0]  CLR_LAST  = CLR_W'(CLR_N - 1);

    logic [STATE_W-1:0] start_reg, final_reg, state_reg;
    logic [STEP_W-1:0]  limit_reg, steps_reg;
    logic [HEAD_W-1:0]  head_reg;
    logic [CLR_W-1:0]   clr_cnt_reg;
    logic [IN_W-1:0]    item_reg;
    logic [CMD_W-1:0]   cmd_reg;
    logic [STS_W-1:0]   status_reg;
    logic [SYMF_W-1:0]  cdata_reg;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic [STS_W-1:0]   m_tuser_reg;
    logic [SYM_W-1:0]   tape_rd_reg;
    logic [ENT_W-1:0]   tbl_rd_reg;

    logic [SYM_W-1:0] tape_mem [TAPE_CELLS];
    logic [ENT_W-1:0] tbl_mem  [TABLE_DEPTH];

    logic [STATE_W-1:0] f_from, f_to, ent_to;
    logic [SYM_W-1:0]   f_match, f_osym, f_csym, ent_sym, tape_wdata;
    logic [1:0]         f_move, ent_move;
    logic [CELL_W-1:0]  f_cell;
    logic               ent_valid, from_ok, cell_ok, state_ok, commit_ok;
    logic               clr_in_tape, clr_in_tbl;
    logic [STS_W-1:0]   pre_status, post_status;
    logic [HEAD_W-1:0]  next_head, tape_waddr, tape_raddr;
    logic               tape_we, tbl_we;
    logic [TI_W-1:0]    tbl_waddr, tbl_raddr;
    logic [ENT_W-1:0]   tbl_wdata;

    assign f_from  = item_reg[5:0];
    assign f_match = item_reg[6 +: SYM_W];
    assign f_to    = item_reg[19:14];
    assign f_osym  = item_reg[20 +: SYM_W];
    assign f_move  = item_reg[29:28];
    assign f_cell  = item_reg[39:30];
    assign f_csym  = item_reg[40 +: SYM_W];

    assign ent_to    = tbl_rd_reg[STATE_W-1:0];
    assign ent_sym   = tbl_rd_reg[STATE_W +: SYM_W];
    assign ent_move  = tbl_rd_reg[STATE_W+SYM_W +: 2];
    assign ent_valid = tbl_rd_reg[ENT_W-1];

    assign from_ok     = 32'(f_from) < STATE_LIM;
    assign cell_ok     = 32'(f_cell) < TAPE_LIM;
    assign state_ok    = 32'(state_reg) < STATE_LIM;
    assign clr_in_tape = 32'(clr_cnt_reg) < TAPE_LIM;
    assign clr_in_tbl  = 32'(clr_cnt_reg) < TBL_LIM;

    always_comb begin
        if (state_reg == final_reg) begin
            pre_status = STS_FINAL;
        end else if (steps_reg >= limit_reg) begin
            pre_status = STS_LIMIT;
        end else if (!state_ok) begin
            pre_status = STS_MISSING;
        end else begin
            pre_status = STS_DONE;
        end
    end

    always_comb begin
        next_head = head_reg;
        if (!ent_valid) begin
            post_status = STS_MISSING;
        end else if (ent_move == MOVE_LEFT && head_reg == '0) begin
            post_status = STS_EDGE;
        end else if (ent_move == MOVE_RIGHT && head_reg == HEAD_LAST) begin
            post_status = STS_EDGE;
        end else begin
            post_status = STS_DONE;
            if (ent_move == MOVE_LEFT) begin
                next_head = head_reg - HEAD_W'(1);
            end else if (ent_move == MOVE_RIGHT) begin
                next_head = head_reg + HEAD_W'(1);
            end
        end
    end

    assign commit_ok = ctl.step_commit && (post_status == STS_DONE);

    always_comb begin
        tape_we    = 1'b0;
        tape_waddr = head_reg;
        tape_wdata = ent_sym;
        if (ctl.clr) begin
            tape_we    = clr_in_tape;
            tape_waddr = HEAD_W'(clr_cnt_reg);
            tape_wdata = BLANK;
        end else if (ctl.cell_write) begin
            tape_we    = cell_ok;
            tape_waddr = HEAD_W'(f_cell);
            tape_wdata = f_csym;
        end else if (ctl.step_commit) begin
            tape_we    = commit_ok;
        end
    end

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = {ST_W'(f_from), f_match};
        tbl_wdata = {1'b1, f_move, f_osym, f_to};
        if (ctl.clr) begin
            tbl_we    = clr_in_tbl;
            tbl_waddr = TI_W'(clr_cnt_reg);
            tbl_wdata = '0;
        end else if (ctl.tbl_write) begin
            tbl_we    = from_ok;
        end
    end

    assign tape_raddr = ctl.rd_cell ? HEAD_W'(f_cell) : head_reg;
    assign tbl_raddr  = {ST_W'(state_reg), tape_rd_reg};

    always_ff @(posedge aclk) begin
        if (tape_we) begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rd_reg <= tape_mem[tape_raddr];
    end

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= '0;
            final_reg   <= STATE_W'(1);
            limit_reg   <= '1;
            state_reg   <= '0;
            head_reg    <= '0;
            steps_reg   <= '0;
            clr_cnt_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_START: start_reg <= cfg_data[STATE_W-1:0];
                    REG_FINAL: final_reg <= cfg_data[STATE_W-1:0];
                    REG_LIMIT: limit_reg <= cfg_data;
                    default:   limit_reg <= limit_reg;
                endcase
            end
            if (ctl.clr) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (ctl.run_start) begin
                state_reg <= start_reg;
                head_reg  <= cell_ok ? HEAD_W'(f_cell) : HEAD_LAST;
                steps_reg <= '0;
            end
            if (commit_ok) begin
                state_reg <= ent_to;
                head_reg  <= next_head;
                steps_reg <= steps_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch) begin
            item_reg   <= s_tdata;
            cmd_reg    <= s_tuser;
            status_reg <= STS_DONE;
            cdata_reg  <= '0;
        end
        if (ctl.step_check) begin
            status_reg <= pre_status;
        end
        if (ctl.step_commit) begin
            status_reg <= post_status;
        end
        if (ctl.cdata_latch) begin
            cdata_reg <= cell_ok ? SYMF_W'(tape_rd_reg) : '0;
        end
        if (ctl.out_load) begin
            m_tdata_reg <= {cdata_reg, steps_reg, SYMF_W'(tape_rd_reg),
                            CELL_W'(head_reg), state_reg};
            m_tuser_reg <= status_reg;
        end
    end

    assign sts.clr_last   = (clr_cnt_reg == CLR_LAST);
    assign sts.cmd        = cmd_reg;
    assign sts.pre_refuse = (pre_status != STS_DONE);

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

`default_nettype wire

// File: hw/rtl/turing_machine_step_engine.sv
// From accept to m_tvalid a refused step, load, cell write, run start and unused commands
// pass EXEC, HREAD and OUT, a cell read EXEC, CREAD and OUT, a full step EXEC, SYM, TBL,
// HREAD and OUT (tape read, table read, tape write, then a tape read under the new head).
// One item at a time; the next is accepted in the cycle after the result is registered.
// Reset (aresetn low, synchronous) starts a clearing pass over max(TAPE_CELLS,
// STATE_COUNT << SYMBOL_BITS) addresses (16384 by default); no item is taken.
`default_nettype none

module turing_machine_step_engine #(
    parameter int STATE_COUNT = 64,
    parameter int TAPE_CELLS  = 1024,
    parameter int SYMBOL_BITS = 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // from_state, match_symbol, to_state, out_symbol, move, cell_req, cell_symbol
    input  wire logic [tmse_pkg::IN_W-1:0]      s_tdata,
    // command
    input  wire logic [tmse_pkg::CMD_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // machine_state, head_cell, head_symbol, steps_taken, cell_data
    output logic [tmse_pkg::OUT_W-1:0]          m_tdata,
    // status
    output logic [tmse_pkg::STS_W-1:0]          m_tuser,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tmse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tmse_pkg::CFG_W-1:0]     cfg_data
);
    import tmse_pkg::*;

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    tmse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctl      (ctl),
        .sts      (sts)
    );

    tmse_dp #(
        .STATE_COUNT (STATE_COUNT),
        .TAPE_CELLS  (TAPE_CELLS),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: test/tb_turing_machine_step_engine.sv
`timescale 1ns / 100ps

module tb_turing_machine_step_engine;
    import tmse_pkg::*;

    localparam logic [1:0]        MOVE_STAY = 2'b00;
    localparam logic [1:0]        MOVE_NEG2 = 2'b10;
    localparam logic [SYMF_W-1:0] BLANK     = 8'd32;
    localparam logic [CELL_W-1:0] LAST_CELL = 10'd1023;
    localparam int                LONG_HOLD = 200;
    localparam int                RANDOM_ITEMS = 420;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [STATE_W-1:0] from_st;
        logic [SYMF_W-1:0]  match_sym;
        logic [STATE_W-1:0] to_st;
        logic [SYMF_W-1:0]  out_sym;
        logic [1:0]         move;
        logic [CELL_W-1:0]  cell_req;
        logic [SYMF_W-1:0]  cell_sym;
    } tm_cmd_t;

    typedef struct {
        logic [STS_W-1:0]   status;
        logic [STATE_W-1:0] mstate;
        logic [CELL_W-1:0]  head;
        logic [SYMF_W-1:0]  hsym;
        logic [STEP_W-1:0]  steps;
        logic [SYMF_W-1:0]  cdata;
    } tm_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata   = '0;
    logic [CMD_W-1:0]     s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic [STS_W-1:0]     m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    logic [SYMF_W-1:0]    tape_img [0:1023];
    logic [16:0]          rule_tbl [0:16383];
    logic [CELL_W-1:0]    head_pos;
    logic [STATE_W-1:0]   cur_state;
    logic [STEP_W-1:0]    step_cnt;
    logic [STATE_W-1:0]   cfg_start;
    logic [STATE_W-1:0]   cfg_final;
    logic [STEP_W-1:0]    cfg_limit;

    tm_result_t replies_due [$];
    int         mismatch_cnt = 0;
    int         items_sent   = 0;
    bit         tx_idle      = 1'b1;
    bit         rx_idle      = 1'b1;
    bit         tx_on        = 1'b0;
    int         hold_req     = 0;
    int         hold_ack     = 0;
    int         hold_left    = 0;
    int         rx_gap       = 0;

    turing_machine_step_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 50);
    endfunction

    function automatic tm_result_t tm_apply(tm_cmd_t it);
        tm_result_t       r;
        logic [16:0]      rule;
        logic [CELL_W-1:0] nxt;
        r.status = STS_DONE;
        r.cdata  = '0;
        case (it.cmd)
            CMD_LOAD: rule_tbl[{it.from_st, it.match_sym}] = {1'b1, it.move, it.out_sym, it.to_st};
            CMD_WRITE: tape_img[it.cell_req] = it.cell_sym;
            CMD_START: begin
                cur_state = cfg_start;
                head_pos  = it.cell_req;
                step_cnt  = '0;
            end
            CMD_STEP: begin
                rule = rule_tbl[{cur_state, tape_img[head_pos]}];
                nxt  = head_pos;
                if (cur_state == cfg_final) r.status = STS_FINAL;
                else if (step_cnt >= cfg_limit) r.status = STS_LIMIT;
                else if (!rule[16]) r.status = STS_MISSING;
                else if (rule[15:14] == MOVE_LEFT && head_pos == '0) r.status = STS_EDGE;
                else if (rule[15:14] == MOVE_RIGHT && head_pos == LAST_CELL) r.status = STS_EDGE;
                if (r.status == STS_DONE) begin
                    if (rule[15:14] == MOVE_LEFT) nxt = head_pos - CELL_W'(1);
                    else if (rule[15:14] == MOVE_RIGHT) nxt = head_pos + CELL_W'(1);
                    tape_img[head_pos] = rule[13:6];
                    head_pos  = nxt;
                    cur_state = rule[5:0];
                    step_cnt  = step_cnt + STEP_W'(1);
                end
            end
            CMD_READ: r.cdata = tape_img[it.cell_req];
            default: ;
        endcase
        r.mstate = cur_state;
        r.head   = head_pos;
        r.hsym   = tape_img[head_pos];
        r.steps  = step_cnt;
        return r;
    endfunction

    function automatic tm_cmd_t noise_item(logic [CMD_W-1:0] cmd);
        tm_cmd_t it;
        it.cmd       = cmd;
        it.from_st   = STATE_W'($urandom);
        it.match_sym = SYMF_W'($urandom);
        it.to_st     = STATE_W'($urandom);
        it.out_sym   = SYMF_W'($urandom);
        it.move      = 2'($urandom);
        it.cell_req  = CELL_W'($urandom);
        it.cell_sym  = SYMF_W'($urandom);
        return it;
    endfunction

    task automatic flag_mismatch(string what);
        mismatch_cnt++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // receiver side: long hold-off on request, else random gaps
    always @(negedge aclk) begin
        if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_idle) rx_gap = pick_gap();
        end
    end

    always @(posedge aclk) begin
        tm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (replies_due.size() == 0) begin
                flag_mismatch("result with no item pending");
            end else begin
                want = replies_due.pop_front();
                check_field("status", 32'(m_tuser), 32'(want.status));
                check_field("machine_state", 32'(m_tdata[5:0]), 32'(want.mstate));
                check_field("head_cell", 32'(m_tdata[15:6]), 32'(want.head));
                check_field("head_symbol", 32'(m_tdata[23:16]), 32'(want.hsym));
                check_field("steps_taken", m_tdata[55:24], want.steps);
                check_field("cell_data", 32'(m_tdata[63:56]), 32'(want.cdata));
            end
        end
    end

    task automatic push_item(tm_cmd_t it);
        int gap;
        gap = tx_idle ? pick_gap() : 0;
        if (gap > 0) begin
            if (tx_on) s_tvalid <= 1'b0;
            tx_on = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        tx_on = 1'b1;
        s_tuser <= it.cmd;
        s_tdata <= {it.cell_sym, it.cell_req, it.move, it.out_sym, it.to_st,
                    it.match_sym, it.from_st};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        replies_due.insert(replies_due.size(), tm_apply(it));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_load(logic [STATE_W-1:0] from_st, logic [SYMF_W-1:0] match_sym,
                             logic [STATE_W-1:0] to_st, logic [SYMF_W-1:0] out_sym,
                             logic [1:0] move);
        tm_cmd_t it;
        it = noise_item(CMD_LOAD);
        it.from_st   = from_st;
        it.match_sym = match_sym;
        it.to_st     = to_st;
        it.out_sym   = out_sym;
        it.move      = move;
        push_item(it);
    endtask

    task automatic send_write(logic [CELL_W-1:0] cell_req, logic [SYMF_W-1:0] sym);
        tm_cmd_t it;
        it = noise_item(CMD_WRITE);
        it.cell_req = cell_req;
        it.cell_sym = sym;
        push_item(it);
    endtask

    task automatic send_start(logic [CELL_W-1:0] cell_req);
        tm_cmd_t it;
        it = noise_item(CMD_START);
        it.cell_req = cell_req;
        push_item(it);
    endtask

    task automatic send_read(logic [CELL_W-1:0] cell_req);
        tm_cmd_t it;
        it = noise_item(CMD_READ);
        it.cell_req = cell_req;
        push_item(it);
    endtask

    task automatic send_step();
        push_item(noise_item(CMD_STEP));
    endtask

    task automatic settle_outputs();
        if (tx_on) s_tvalid <= 1'b0;
        tx_on = 1'b0;
        while (replies_due.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_START: cfg_start = val[STATE_W-1:0];
            REG_FINAL: cfg_final = val[STATE_W-1:0];
            REG_LIMIT: cfg_limit = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(logic [STATE_W-1:0] st, logic [STATE_W-1:0] fin,
                                logic [STEP_W-1:0] lim);
        settle_outputs();
        write_reg(REG_START, CFG_W'(st));
        write_reg(REG_FINAL, CFG_W'(fin));
        write_reg(REG_LIMIT, lim);
    endtask

    // reset defaults, every command, edges, odd move code, unused commands
    task automatic test_basic_commands();
        send_step();
        send_read('0);
        send_read(LAST_CELL);
        send_write('0, 8'hFF);
        send_write(LAST_CELL, 8'h00);
        send_load(6'd0, BLANK, 6'd63, 8'h00, MOVE_RIGHT);
        send_load(6'd63, BLANK, 6'd63, 8'hFF, MOVE_NEG2);
        send_load(6'd0, 8'hFF, 6'd0, 8'hAA, MOVE_LEFT);
        send_load(6'd63, 8'hFF, 6'd1, 8'h55, MOVE_STAY);
        send_start('0);
        send_step();
        send_start(10'd1);
        repeat (4) send_step();
        send_start(LAST_CELL);
        send_load(6'd0, 8'h00, 6'd5, 8'h07, MOVE_RIGHT);
        send_step();
        push_item(noise_item(CMD_READ + 1'b1));
        push_item(noise_item('1));
        send_read(10'd2);
        send_read(10'd1);
    endtask

    // final before limit before missing; counter stops at the limit
    task automatic test_step_priority();
        program_regs('1, '0, '0);
        send_start(10'd500);
        send_step();
        program_regs('1, '1, '0);
        send_start(10'd500);
        send_step();
        program_regs(6'd10, 6'd1, '0);
        send_start(10'd500);
        send_step();
        program_regs('1, '0, 32'd1);
        send_start(10'd500);
        send_step();
        send_step();
        program_regs('0, 6'd1, '1);
    endtask

    task automatic test_random_programs();
        int                 n_states;
        int                 n_steps;
        logic [STATE_W-1:0] states [4];
        logic [SYMF_W-1:0]  syms [3];
        logic [STATE_W-1:0] fin;
        logic [STEP_W-1:0]  lim;
        logic [CELL_W-1:0]  head0;
        logic [STATE_W-1:0] to_st;
        logic [SYMF_W-1:0]  osym;
        logic [1:0]         mv;
        while (items_sent < RANDOM_ITEMS) begin
            n_states = $urandom_range(2, 4);
            for (int i = 0; i < 4; i++) states[i] = STATE_W'($urandom);
            case ($urandom_range(0, 5))
                0: states[0] = '0;
                1: states[0] = '1;
                default: ;
            endcase
            syms[0] = BLANK;
            for (int i = 1; i < 3; i++) begin
                case ($urandom_range(0, 5))
                    0: syms[i] = '0;
                    1: syms[i] = '1;
                    default: syms[i] = SYMF_W'($urandom);
                endcase
            end
            case ($urandom_range(0, 7))
                0: fin = '0;
                1: fin = '1;
                2: fin = STATE_W'($urandom);
                default: fin = states[n_states-1];
            endcase
            case ($urandom_range(0, 9))
                0: lim = '0;
                1, 2: lim = $urandom_range(1, 30);
                3: lim = $urandom;
                default: lim = '1;
            endcase
            case ($urandom_range(0, 9))
                0: head0 = '0;
                1: head0 = LAST_CELL;
                default: head0 = CELL_W'($urandom);
            endcase
            program_regs(states[0], fin, lim);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            for (int s = 0; s < n_states; s++) begin
                for (int y = 0; y < 3; y++) begin
                    if ($urandom_range(0, 9) != 0) begin
                        to_st = ($urandom_range(0, 4) == 0) ? fin
                                : states[$urandom_range(0, n_states - 1)];
                        osym  = ($urandom_range(0, 4) == 0) ? SYMF_W'($urandom)
                                : syms[$urandom_range(0, 2)];
                        case ($urandom_range(0, 7))
                            0: mv = MOVE_STAY;
                            1: mv = MOVE_NEG2;
                            2, 3, 4: mv = MOVE_LEFT;
                            default: mv = MOVE_RIGHT;
                        endcase
                        send_load(states[s], syms[y], to_st, osym, mv);
                    end
                end
            end
            repeat ($urandom_range(2, 6))
                send_write(CELL_W'(head0 + $urandom_range(0, 10) - 3),
                           syms[$urandom_range(0, 2)]);
            send_start(head0);
            n_steps = $urandom_range(8, 40);
            for (int k = 0; k < n_steps; k++) begin
                if ($urandom_range(0, 7) == 0)
                    send_read(CELL_W'(head0 + $urandom_range(0, 12) - 6));
                if ($urandom_range(0, 19) == 0) push_item(noise_item(CMD_W'($urandom)));
                send_step();
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_noise_items();
        repeat (60) push_item(noise_item(CMD_W'($urandom)));
    endtask

    // block fills up while the receiver holds off, then the sender waits for all
    task automatic test_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_req++;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 2) send_read(CELL_W'($urandom));
            else send_step();
        end
        settle_outputs();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        repeat (10) send_step();
    endtask

    initial begin
        for (int i = 0; i < 1024; i++) tape_img[i] = BLANK;
        for (int i = 0; i < 16384; i++) rule_tbl[i] = '0;
        head_pos  = '0;
        cur_state = '0;
        step_cnt  = '0;
        cfg_start = '0;
        cfg_final = 6'd1;
        cfg_limit = '1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        test_basic_commands();
        test_step_priority();
        test_random_programs();
        test_noise_items();
        test_backpressure();
        settle_outputs();
        repeat (20) @(negedge aclk);
        if (mismatch_cnt == 0 && replies_due.size() == 0) begin
            $display("turing_machine_step_engine regression: pass");
        end else begin
            $display("turing_machine_step_engine regression: fail");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("turing_machine_step_engine regression: fail");
        $finish;
    end

endmodule
